// ===== rtl/prg_pkg.sv =====
// Shared constants, types and codes for the palette ramp row generator.
// Used by every module of the block; depends on nothing else.
package prg_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int MAX_WIDTH     = 64;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CFG_W_W = 7;
    localparam int CFG_H_W = 13;
    localparam int CFG_C_W = 5;
    localparam int ROW_W   = 12;
    localparam int SLOT_W  = 4;
    localparam int COMP_W  = 8;

    localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int NCOL_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int HM1_W   = CFG_H_W;
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int IDX_W   = $clog2(MAX_WIDTH);
    localparam int FRAC_W  = 16;
    localparam int SPAN_W  = NCOL_W + FRAC_W;
    localparam int PROD_W  = ROW_W + SPAN_W;

    localparam int Q_ONE_P001    = 65601;
    localparam int DEFAULT_WIDTH = 8;

    localparam int DIV_STEPS = 5;
    localparam int CNT_W     = $clog2(SPAN_W + 1);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLORS = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic {
        K_LOAD,
        K_RENDER
    } t_kind;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_READ,
        BS_BLEND
    } t_bstate;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_kind             kind;
        logic [PAL_AW-1:0] slot;
        t_pix              color;
        logic [ROW_W-1:0]  row;
    } t_qent;

    typedef struct packed {
        logic [NCOL_W-1:0] ncol;
        logic [HM1_W-1:0]  hm1;
        logic [W_W-1:0]    width;
    } t_rcfg;

endpackage

// ===== rtl/prg_front.sv =====
// Front end: takes input beats, classifies them and derives the effective ramp settings.
// Depends on prg_pkg; feeds prg_fifo and supplies settings to the back end.
module prg_front import prg_pkg::*; (
    input  logic [CFG_W_W-1:0] i_ramp_width,
    input  logic [CFG_H_W-1:0] i_ramp_height,
    input  logic [CFG_C_W-1:0] i_color_count,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [COMP_W-1:0]  i_red_in,
    input  logic [COMP_W-1:0]  i_green_in,
    input  logic [COMP_W-1:0]  i_blue_in,
    input  logic [ROW_W-1:0]   i_row,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output t_qent              o_entry,
    output t_rcfg              o_cfg
);

    logic [NCOL_W-1:0]  ncol;
    logic [CFG_H_W-1:0] h_sat;
    logic [CFG_H_W-1:0] two_n;
    logic [CFG_H_W-1:0] h_eff;
    logic [HM1_W-1:0]   hm1;
    logic [W_W-1:0]     w_eff;
    logic               load_ok;
    logic               render_ok;

    always_comb begin
        if (32'(i_color_count) > PALETTE_DEPTH) begin
            ncol = NCOL_W'(PALETTE_DEPTH);
        end else begin
            ncol = NCOL_W'(i_color_count);
        end

        if (32'(i_ramp_height) > MAX_HEIGHT) begin
            h_sat = CFG_H_W'(MAX_HEIGHT);
        end else begin
            h_sat = i_ramp_height;
        end
        two_n = CFG_H_W'({ncol, 1'b0});
        if (h_sat < two_n) begin
            h_eff = two_n;
        end else begin
            h_eff = h_sat;
        end
        hm1 = HM1_W'(h_eff - CFG_H_W'(1));

        if (i_ramp_width == '0) begin
            w_eff = W_W'(DEFAULT_WIDTH);
        end else if (32'(i_ramp_width) > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(i_ramp_width);
        end
    end

    assign o_cfg.ncol  = ncol;
    assign o_cfg.hm1   = hm1;
    assign o_cfg.width = w_eff;

    assign load_ok   = (i_cmd == CMD_LOAD) && (32'(i_slot) < PALETTE_DEPTH);
    assign render_ok = (i_cmd == CMD_RENDER) && (i_color_count >= CFG_C_W'(2));

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && (load_ok || render_ok);

    always_comb begin
        o_entry.kind        = (i_cmd == CMD_RENDER) ? K_RENDER : K_LOAD;
        o_entry.slot        = PAL_AW'(i_slot);
        o_entry.color.red   = i_red_in;
        o_entry.color.green = i_green_in;
        o_entry.color.blue  = i_blue_in;
        if ({1'b0, i_row} > (ROW_W + 1)'(hm1)) begin
            o_entry.row = ROW_W'(hm1);
        end else begin
            o_entry.row = i_row;
        end
    end

endmodule

// ===== rtl/prg_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on prg_pkg for the entry type and depth.
module prg_fifo import prg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_qent o_head
);

    t_qent            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic [QAW-1:0]   n_wp;
    logic [QAW-1:0]   n_rp;
    logic [QAW:0]     n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (QAW + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (QAW + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (QAW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

// ===== rtl/prg_back.sv =====
// Back end: palette store, blend position divider and colour blend for each command.
// Depends on prg_pkg; pops prg_fifo and hands row colours to prg_emit.
module prg_back import prg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_rcfg i_cfg,
    input  logic  i_empty,
    input  t_qent i_head,
    output logic  o_pop,
    input  logic  i_emit_ready,
    output logic  o_emit_load,
    output t_pix  o_emit_color
);

    function automatic logic [COMP_W-1:0] blend_lane(
        input logic [COMP_W-1:0] a,
        input logic [COMP_W-1:0] b,
        input logic [FRAC_W-1:0] f
    );
        logic signed [COMP_W:0]          d;
        logic signed [FRAC_W+COMP_W+1:0] m;
        logic signed [FRAC_W+COMP_W+1:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        m = $signed({1'b0, f}) * d;
        s = (m >>> FRAC_W) + $signed({{(FRAC_W + 2){1'b0}}, a});
        return s[COMP_W-1:0];
    endfunction

    t_bstate            r_state;
    t_bstate            n_state;
    logic [HM1_W-1:0]   r_rem;
    logic [SPAN_W-1:0]  r_dlo;
    logic [SPAN_W-1:0]  r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic [HM1_W-1:0]   n_rem;
    logic [SPAN_W-1:0]  n_dlo;
    logic [SPAN_W-1:0]  n_quo;
    logic [CNT_W-1:0]   n_cnt;
    logic [23:0]        r_pal [PALETTE_DEPTH];
    t_pix               r_c0;
    t_pix               r_c1;
    logic               pal_we;
    logic               pal_re;
    logic               start;
    logic [SPAN_W-1:0]  span;
    logic [PROD_W-1:0]  prod;
    logic [NCOL_W-1:0]  pidx;
    logic [PAL_AW-1:0]  ra0;
    logic [PAL_AW-1:0]  ra1;
    logic [FRAC_W-1:0]  frac;

    assign span = SPAN_W'({i_cfg.ncol, {FRAC_W{1'b0}}}) - SPAN_W'(Q_ONE_P001);
    assign prod = PROD_W'(i_head.row) * PROD_W'(span);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty && i_head.kind == K_RENDER) begin
                    n_state = BS_DIV;
                end
            end
            BS_DIV: begin
                if (32'(r_cnt) <= DIV_STEPS) begin
                    n_state = BS_READ;
                end
            end
            BS_READ: begin
                n_state = BS_BLEND;
            end
            BS_BLEND: begin
                if (i_emit_ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        pal_we      = 1'b0;
        start       = 1'b0;
        pal_re      = 1'b0;
        o_emit_load = 1'b0;
        case (r_state)
            BS_IDLE: begin
                o_pop  = !i_empty;
                pal_we = !i_empty && (i_head.kind == K_LOAD);
                start  = !i_empty && (i_head.kind == K_RENDER);
            end
            BS_DIV: begin
            end
            BS_READ: begin
                pal_re = 1'b1;
            end
            BS_BLEND: begin
                o_emit_load = i_emit_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic [HM1_W:0] trial;
        logic           qb;
        trial = '0;
        qb    = 1'b0;
        n_rem = r_rem;
        n_dlo = r_dlo;
        n_quo = r_quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (32'(r_cnt) > k) begin
                trial = {n_rem, n_dlo[SPAN_W-1]};
                if (trial >= {1'b0, i_cfg.hm1}) begin
                    n_rem = HM1_W'(trial - {1'b0, i_cfg.hm1});
                    qb    = 1'b1;
                end else begin
                    n_rem = HM1_W'(trial);
                    qb    = 1'b0;
                end
                n_dlo = {n_dlo[SPAN_W-2:0], 1'b0};
                n_quo = {n_quo[SPAN_W-2:0], qb};
            end
        end
        if (32'(r_cnt) > DIV_STEPS) begin
            n_cnt = r_cnt - CNT_W'(DIV_STEPS);
        end else begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rem <= HM1_W'(prod >> SPAN_W);
            r_dlo <= prod[SPAN_W-1:0];
            r_cnt <= CNT_W'(SPAN_W);
        end else if (r_state == BS_DIV) begin
            r_rem <= n_rem;
            r_dlo <= n_dlo;
            r_quo <= n_quo;
            r_cnt <= n_cnt;
        end
    end

    assign pidx = r_quo[SPAN_W-1:FRAC_W];
    assign ra0  = PAL_AW'(pidx);
    assign ra1  = PAL_AW'(pidx + NCOL_W'(1));
    assign frac = r_quo[FRAC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[i_head.slot] <= i_head.color;
        end
        if (pal_re) begin
            r_c0 <= r_pal[ra0];
            r_c1 <= r_pal[ra1];
        end
    end

    assign o_emit_color.red   = blend_lane(r_c0.red,   r_c1.red,   frac);
    assign o_emit_color.green = blend_lane(r_c0.green, r_c1.green, frac);
    assign o_emit_color.blue  = blend_lane(r_c0.blue,  r_c1.blue,  frac);

endmodule

// ===== rtl/prg_emit.sv =====
// Pixel emitter: holds one row colour and sends it out once per pixel of the row.
// Depends on prg_pkg; loaded by prg_back.
module prg_emit import prg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [W_W-1:0]    i_width,
    input  logic              i_load,
    input  t_pix              i_color,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COMP_W-1:0] o_red,
    output logic [COMP_W-1:0] o_green,
    output logic [COMP_W-1:0] o_blue,
    output logic              o_last
);

    logic             r_busy;
    t_pix             r_color;
    logic [IDX_W-1:0] r_idx;
    logic             beat;
    logic             last;

    assign last    = (r_idx == IDX_W'(i_width - W_W'(1)));
    assign beat    = r_busy && !i_stall;
    assign o_ready = !r_busy || (beat && last);
    assign o_valid = r_busy;
    assign o_red   = r_color.red;
    assign o_green = r_color.green;
    assign o_blue  = r_color.blue;
    assign o_last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (beat && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_color <= i_color;
            r_idx   <= '0;
        end else if (beat) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

endmodule

// ===== rtl/palette_ramp_row_generator_top.sv =====
// Palette colour ramp row generator: a load beat writes one palette entry, a render beat
// with a colour count of at least two emits one row of a vertical ramp whose colour blends
// two neighbouring palette entries. The back end works on one command at a time: a load is
// written as it is popped, a row colour passes through the product of row and span, divider
// passes that yield the 21 quotient bits at up to five bits each, palette read and blend.
// Pixels leave one per cycle from the emitter while the output is not stalled; the emitter
// overlaps with the next row's colour. A four-entry queue lets input beats arrive while the
// output is stalled. Depends on prg_pkg, prg_front, prg_fifo, prg_back and prg_emit.
module palette_ramp_row_generator_top import prg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [COMP_W-1:0] i_red_in,
    input  logic [COMP_W-1:0] i_green_in,
    input  logic [COMP_W-1:0] i_blue_in,
    input  logic [ROW_W-1:0]  i_row,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [COMP_W-1:0] o_red_out,
    output logic [COMP_W-1:0] o_green_out,
    output logic [COMP_W-1:0] o_blue_out,
    output logic              o_last_pixel
);

    logic [CFG_W_W-1:0] r_ramp_width;
    logic [CFG_H_W-1:0] r_ramp_height;
    logic [CFG_C_W-1:0] r_color_count;
    logic               wr_en;
    logic [1:0]         reg_idx;
    t_rcfg              cfg;
    logic               push;
    t_qent              entry;
    logic               full;
    logic               empty;
    t_qent              head;
    logic               pop;
    logic               emit_ready;
    logic               emit_load;
    t_pix               emit_color;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_width  <= CFG_W_W'(8);
            r_ramp_height <= CFG_H_W'(32);
            r_color_count <= CFG_C_W'(2);
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  r_ramp_width  <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: r_ramp_height <= pwdata[CFG_H_W-1:0];
                REG_COLORS: r_color_count <= pwdata[CFG_C_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = DATA_W'(r_ramp_width);
            REG_HEIGHT: prdata = DATA_W'(r_ramp_height);
            REG_COLORS: prdata = DATA_W'(r_color_count);
            default:    prdata = '0;
        endcase
    end

    prg_front u_front (
        .i_ramp_width  (r_ramp_width),
        .i_ramp_height (r_ramp_height),
        .i_color_count (r_color_count),
        .i_valid       (i_in_valid),
        .i_cmd         (i_cmd),
        .i_slot        (i_slot),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_row         (i_row),
        .i_full        (full),
        .o_stall       (o_in_stall),
        .o_push        (push),
        .o_entry       (entry),
        .o_cfg         (cfg)
    );

    prg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    prg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .i_emit_ready (emit_ready),
        .o_emit_load  (emit_load),
        .o_emit_color (emit_color)
    );

    prg_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_width (cfg.width),
        .i_load  (emit_load),
        .i_color (emit_color),
        .o_ready (emit_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out),
        .o_last  (o_last_pixel)
    );

endmodule

// ===== rtl/prg_checker.sv =====
// Port-level checks on the pixel output of the ramp generator, bound to the top level.
// Depends on prg_pkg and palette_ramp_row_generator_top.
module prg_checker import prg_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [COMP_W-1:0] o_red_out,
    input logic [COMP_W-1:0] o_green_out,
    input logic [COMP_W-1:0] o_blue_out,
    input logic              o_last_pixel
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat offered straight after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out) && $stable(o_last_pixel))
        else $error("stalled output beat changed");

    a_row_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_pixel |=> o_out_valid)
        else $error("row ended before its last pixel");

    a_row_one_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_pixel |=> $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out))
        else $error("colour changed within a row");

endmodule

bind palette_ramp_row_generator_top prg_checker u_prg_checker (.*);

// ===== dv/prg_ramp_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the palette ramp row generator: follows register writes, palette loads and
// row requests, predicts every pixel beat of each row and compares the pixel stream with it.
// Depends on prg_pkg only.
module prg_ramp_checker import prg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [COMP_W-1:0] i_red_in,
    input  logic [COMP_W-1:0] i_green_in,
    input  logic [COMP_W-1:0] i_blue_in,
    input  logic [ROW_W-1:0]  i_row,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [COMP_W-1:0] i_red_out,
    input  logic [COMP_W-1:0] i_green_out,
    input  logic [COMP_W-1:0] i_blue_out,
    input  logic              i_last_pixel,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        t_pix colour;
        logic end_of_row;
    } t_ramp_beat;

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [CFG_C_W-1:0] colours_reg;
    t_pix               shade_mem [PALETTE_DEPTH];
    t_ramp_beat         pixel_q [$];
    int                 mismatches = 0;

    function automatic logic [COMP_W-1:0] mix_component(input logic [COMP_W-1:0] lo,
                                                        input logic [COMP_W-1:0] hi,
                                                        input int unsigned frac);
        int unsigned acc;
        acc = ((32'd1 << FRAC_W) - frac) * lo + frac * hi;
        return acc[FRAC_W +: COMP_W];
    endfunction

    task automatic predict_row(input logic [ROW_W-1:0] row_idx);
        int unsigned ncol, npix, rows, r, span, p, frac;
        logic [63:0] pos;
        t_pix        lo, hi, mix;
        t_ramp_beat  beat;
        ncol = colours_reg;
        if (ncol >= 2) begin
            if (ncol > PALETTE_DEPTH) ncol = PALETTE_DEPTH;
            npix = (width_reg == 0) ? DEFAULT_WIDTH : width_reg;
            if (npix > MAX_WIDTH) npix = MAX_WIDTH;
            rows = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
            if (rows < 2 * ncol) rows = 2 * ncol;
            r = (row_idx > rows - 1) ? rows - 1 : row_idx;
            span = ncol * (32'd1 << FRAC_W) - Q_ONE_P001;
            pos = 64'(r) * 64'(span) / 64'(rows - 1);
            p = 32'(pos >> FRAC_W);
            frac = 32'(pos[FRAC_W-1:0]);
            if (p > ncol - 2) p = ncol - 2;
            lo = shade_mem[p];
            hi = shade_mem[p + 1];
            mix.red   = mix_component(lo.red, hi.red, frac);
            mix.green = mix_component(lo.green, hi.green, frac);
            mix.blue  = mix_component(lo.blue, hi.blue, frac);
            for (int i = 0; i < npix; i++) begin
                beat.colour = mix;
                beat.end_of_row = (i == npix - 1);
                pixel_q.push_back(beat);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_ramp_beat want;
        if (!i_rst_n) begin
            width_reg = 7'd8;
            height_reg = 13'd32;
            colours_reg = 5'd2;
            pixel_q.delete();
            mismatches = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_WIDTH:  width_reg = i_pwdata[CFG_W_W-1:0];
                    REG_HEIGHT: height_reg = i_pwdata[CFG_H_W-1:0];
                    REG_COLORS: colours_reg = i_pwdata[CFG_C_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == CMD_LOAD)
                    shade_mem[i_slot] = {i_red_in, i_green_in, i_blue_in};
                else
                    predict_row(i_row);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    $error("pixel beat with none expected: red %0d green %0d blue %0d last %0d",
                           i_red_out, i_green_out, i_blue_out, i_last_pixel);
                    mismatches++;
                end else begin
                    want = pixel_q.pop_front();
                    if (i_red_out !== want.colour.red) begin
                        $error("red_out: expected %0d, got %0d", want.colour.red, i_red_out);
                        mismatches++;
                    end
                    if (i_green_out !== want.colour.green) begin
                        $error("green_out: expected %0d, got %0d",
                               want.colour.green, i_green_out);
                        mismatches++;
                    end
                    if (i_blue_out !== want.colour.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.colour.blue, i_blue_out);
                        mismatches++;
                    end
                    if (i_last_pixel !== want.end_of_row) begin
                        $error("last_pixel: expected %0d, got %0d",
                               want.end_of_row, i_last_pixel);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= pixel_q.size();
    end

endmodule

// ===== dv/tb_palette_ramp_row_generator_top.sv =====
`timescale 1ns / 1ps
// Top of the palette ramp row generator testbench: clock, reset, register writes, palette
// loads and row requests with random gaps and output stalls, and the final verdict.
// Depends on prg_pkg, palette_ramp_row_generator_top and prg_ramp_checker.
module tb_palette_ramp_row_generator_top;
    import prg_pkg::*;

    localparam int         CLK_HALF        = 5;
    localparam logic [1:0] REG_SPARE       = 2'd3;
    localparam int         DRAIN_CYCLES    = 100;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         BEATS_PER_PHASE = 44;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_cmd;
    logic [SLOT_W-1:0] i_slot;
    logic [COMP_W-1:0] i_red_in;
    logic [COMP_W-1:0] i_green_in;
    logic [COMP_W-1:0] i_blue_in;
    logic [ROW_W-1:0]  i_row;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [COMP_W-1:0] o_red_out;
    logic [COMP_W-1:0] o_green_out;
    logic [COMP_W-1:0] o_blue_out;
    logic              o_last_pixel;
    int                fail_count;
    int                pending;
    bit                in_idle_on = 1'b1;
    bit                out_idle_on = 1'b1;

    palette_ramp_row_generator_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_slot       (i_slot),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_row        (i_row),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_last_pixel (o_last_pixel)
    );

    prg_ramp_checker ramp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_slot       (i_slot),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_row        (i_row),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_red_out    (o_red_out),
        .i_green_out  (o_green_out),
        .i_blue_out   (o_blue_out),
        .i_last_pixel (o_last_pixel),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic apb_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({reg_idx, 2'b00});
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_ramp(input int unsigned w, input int unsigned h, input int unsigned c);
        settle();
        apb_write(REG_WIDTH, DATA_W'(($urandom() << CFG_W_W) | w));
        apb_write(REG_HEIGHT, DATA_W'(($urandom() << CFG_H_W) | h));
        apb_write(REG_COLORS, DATA_W'(($urandom() << CFG_C_W) | c));
    endtask

    task automatic push_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input t_pix colour, input logic [ROW_W-1:0] row_idx);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_slot <= slot;
        i_red_in <= colour.red;
        i_green_in <= colour.green;
        i_blue_in <= colour.blue;
        i_row <= row_idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                hold = out_idle_on ? $urandom_range(0, 6) : 0;
                if (hold > 0) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        t_pix        shade;
        int unsigned w, h, c, lim, pick;
        logic [ROW_W-1:0] row_idx;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_cmd = CMD_LOAD;
        i_slot = '0;
        i_red_in = '0;
        i_green_in = '0;
        i_blue_in = '0;
        i_row = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(CMD_LOAD, 4'd0, '0, '0);
        push_beat(CMD_LOAD, 4'd1, '1, '0);
        push_beat(CMD_RENDER, '0, '0, 12'd0);
        push_beat(CMD_RENDER, '1, '1, 12'd16);
        push_beat(CMD_RENDER, '0, '0, 12'd31);
        push_beat(CMD_RENDER, '0, '0, '1);
        set_ramp(0, 0, 0);
        push_beat(CMD_RENDER, '0, '0, 12'd5);
        set_ramp(0, 1, 1);
        push_beat(CMD_RENDER, '0, '0, '1);
        set_ramp(1, 1, 2);
        push_beat(CMD_RENDER, '0, '0, 12'd3);
        push_beat(CMD_RENDER, '0, '0, '1);
        for (int s = 2; s < PALETTE_DEPTH; s++) begin
            shade = {8'hA5 ^ 8'(s * 17), 8'($urandom()), 8'h5A ^ 8'(s * 17)};
            push_beat(CMD_LOAD, SLOT_W'(s), shade, ROW_W'($urandom()));
        end
        set_ramp((1 << CFG_W_W) - 1, (1 << CFG_H_W) - 1, (1 << CFG_C_W) - 1);
        apb_write(REG_SPARE, '1);
        push_beat(CMD_RENDER, '0, '0, 12'd0);
        push_beat(CMD_RENDER, '0, '0, 12'd2048);
        push_beat(CMD_RENDER, '0, '0, '1);
        set_ramp(MAX_WIDTH, MAX_HEIGHT, PALETTE_DEPTH);
        push_beat(CMD_RENDER, '0, '0, '1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) w = 0;
            else if (pick < 7) w = $urandom_range(1, 16);
            else if (pick < 9) w = $urandom_range(17, MAX_WIDTH);
            else w = $urandom_range(MAX_WIDTH + 1, (1 << CFG_W_W) - 1);
            pick = $urandom_range(0, 9);
            if (pick < 6) h = $urandom_range(0, 64);
            else if (pick < 8) h = $urandom_range(65, MAX_HEIGHT);
            else if (pick < 9) h = $urandom_range(MAX_HEIGHT + 1, (1 << CFG_H_W) - 1);
            else h = $urandom_range(0, 3);
            pick = $urandom_range(0, 9);
            if (pick < 8) c = $urandom_range(2, PALETTE_DEPTH);
            else if (pick < 9) c = $urandom_range(0, 1);
            else c = $urandom_range(PALETTE_DEPTH + 1, (1 << CFG_C_W) - 1);
            set_ramp(w, h, c);
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            lim = h + 8;
            if (lim > (1 << ROW_W) - 1) lim = (1 << ROW_W) - 1;
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                shade = 24'($urandom());
                if ($urandom_range(0, 3) == 0)
                    row_idx = ROW_W'($urandom());
                else
                    row_idx = ROW_W'($urandom_range(0, lim));
                if ($urandom_range(0, 9) < 7)
                    push_beat(CMD_RENDER, SLOT_W'($urandom()), shade, row_idx);
                else
                    push_beat(CMD_LOAD, SLOT_W'($urandom()), shade, row_idx);
            end
        end

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== palette_ramp_row_generator_top.f =====
rtl/prg_pkg.sv
rtl/prg_front.sv
rtl/prg_fifo.sv
rtl/prg_back.sv
rtl/prg_emit.sv
rtl/palette_ramp_row_generator_top.sv
rtl/prg_checker.sv
dv/prg_ramp_checker.sv
dv/tb_palette_ramp_row_generator_top.sv
